// ----- rtl/led_blink_pattern_sequencer_core_macros.svh -----
// assertion macros shared by the led blink pattern sequencer rtl
`ifndef LED_BLINK_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_CORE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define LBPS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger in one cycle implies the consequence in the following cycle
`define LBPS_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lbps_pkg.sv -----
// types, codes and timing constants of the led blink pattern sequencer
package lbps_pkg;

  localparam int PERIOD_BITS = 13;

  typedef logic [PERIOD_BITS-1:0] period_t;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SELECT = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_TOGGLE = 3'd4
  } opcode_t;

  // pattern codes
  typedef enum logic [2:0] {
    PAT_OFF     = 3'd0,
    PAT_ON      = 3'd1,
    PAT_SLOW    = 3'd2,
    PAT_FAST    = 3'd3,
    PAT_DOUBLE  = 3'd4,
    PAT_TRIPLE  = 3'd5,
    PAT_CONN    = 3'd6,
    PAT_SUNRISE = 3'd7
  } pattern_t;

  // phase durations in milliseconds
  localparam period_t T_SLOW       = period_t'(1000 / 2);
  localparam period_t T_FAST       = period_t'(250 / 2);
  localparam period_t T_CONN_ON    = period_t'(50);
  localparam period_t T_CONN_OFF   = period_t'(5000 - 50);
  localparam period_t T_SUNRISE    = period_t'(2000 / 2);
  localparam period_t T_MB_ON      = period_t'(100);
  localparam period_t T_MB_OFF     = period_t'(100);
  localparam period_t T_MB_PAUSE   = period_t'(800);
  localparam period_t T_RESET_LOAD = period_t'(1000);

  // blink counts of the multi-blink patterns
  localparam logic [1:0] BLINKS_DOUBLE = 2'd2;
  localparam logic [1:0] BLINKS_TRIPLE = 2'd3;

  // complete sequencer state
  typedef struct packed {
    logic       led_lit;
    pattern_t   current_pattern;
    logic       timer_running;
    period_t    ticks_left;
    period_t    reload_period;
    logic [1:0] blinks_done;
    logic [1:0] blinks_wanted;
    logic       pausing;
  } lbps_state_t;

endpackage

// ----- rtl/lbps_step.sv -----
// next-state logic of the sequencer for one item
module lbps_step (
  input  lbps_pkg::lbps_state_t state,
  input  logic [2:0]            opcode,
  input  logic [2:0]            pattern_code,
  output lbps_pkg::lbps_state_t state_next
);
  import lbps_pkg::*;

  lbps_state_t exp_st;
  lbps_state_t tick_st;
  lbps_state_t sel_st;
  logic [1:0]  blinks_inc;
  pattern_t    sel_pat;

  // pattern step taken when the period counter expires, after the reload
  always_comb begin
    exp_st = state;
    exp_st.ticks_left = state.reload_period;
    blinks_inc = state.blinks_done + 2'd1;
    unique case (state.current_pattern)
      PAT_OFF: begin
        exp_st.led_lit = 1'b0;
        exp_st.timer_running = 1'b0;
      end
      PAT_ON: begin
        exp_st.led_lit = 1'b1;
        exp_st.timer_running = 1'b0;
      end
      PAT_DOUBLE, PAT_TRIPLE: begin
        priority if (state.pausing) begin
          exp_st.pausing = 1'b0;
          exp_st.blinks_done = 2'd0;
          exp_st.led_lit = 1'b1;
          exp_st.reload_period = T_MB_ON;
          exp_st.ticks_left = T_MB_ON;
          exp_st.timer_running = 1'b1;
        end else if (state.led_lit) begin
          exp_st.led_lit = 1'b0;
          exp_st.blinks_done = blinks_inc;
          exp_st.timer_running = 1'b1;
          if (blinks_inc >= state.blinks_wanted) begin
            exp_st.pausing = 1'b1;
            exp_st.reload_period = T_MB_PAUSE;
            exp_st.ticks_left = T_MB_PAUSE;
          end else begin
            exp_st.reload_period = T_MB_OFF;
            exp_st.ticks_left = T_MB_OFF;
          end
        end else begin
          exp_st.led_lit = 1'b1;
          exp_st.reload_period = T_MB_ON;
          exp_st.ticks_left = T_MB_ON;
          exp_st.timer_running = 1'b1;
        end
      end
      PAT_CONN: begin
        exp_st.led_lit = ~state.led_lit;
        exp_st.reload_period = state.led_lit ? T_CONN_OFF : T_CONN_ON;
        exp_st.ticks_left = state.led_lit ? T_CONN_OFF : T_CONN_ON;
        exp_st.timer_running = 1'b1;
      end
      default: begin
        // slow, fast and sunrise keep their period
        exp_st.led_lit = ~state.led_lit;
      end
    endcase
  end

  // millisecond tick: count down, expire at one or zero
  always_comb begin
    tick_st = state;
    if (state.timer_running) begin
      if (state.ticks_left <= period_t'(1)) begin
        tick_st = exp_st;
      end else begin
        tick_st.ticks_left = state.ticks_left - period_t'(1);
      end
    end
  end

  // pattern select restarts the phase and, for the timed patterns, the counter
  always_comb begin
    sel_pat = pattern_t'(pattern_code);
    sel_st = state;
    sel_st.current_pattern = sel_pat;
    sel_st.blinks_done = 2'd0;
    sel_st.pausing = 1'b0;
    sel_st.timer_running = 1'b1;
    sel_st.led_lit = 1'b1;
    unique case (sel_pat)
      PAT_OFF: begin
        sel_st.timer_running = 1'b0;
        sel_st.led_lit = 1'b0;
      end
      PAT_ON: begin
        sel_st.timer_running = 1'b0;
      end
      PAT_SLOW: begin
        sel_st.reload_period = T_SLOW;
        sel_st.ticks_left = T_SLOW;
      end
      PAT_FAST: begin
        sel_st.reload_period = T_FAST;
        sel_st.ticks_left = T_FAST;
      end
      PAT_DOUBLE: begin
        sel_st.blinks_wanted = BLINKS_DOUBLE;
        sel_st.reload_period = T_MB_ON;
        sel_st.ticks_left = T_MB_ON;
      end
      PAT_TRIPLE: begin
        sel_st.blinks_wanted = BLINKS_TRIPLE;
        sel_st.reload_period = T_MB_ON;
        sel_st.ticks_left = T_MB_ON;
      end
      PAT_CONN: begin
        sel_st.reload_period = T_CONN_ON;
        sel_st.ticks_left = T_CONN_ON;
      end
      default: begin
        sel_st.reload_period = T_SUNRISE;
        sel_st.ticks_left = T_SUNRISE;
      end
    endcase
  end

  // operation select; unused codes keep the state
  always_comb begin
    state_next = state;
    unique case (opcode)
      OP_TICK:   state_next = tick_st;
      OP_SELECT: state_next = sel_st;
      OP_ON:     state_next.led_lit = 1'b1;
      OP_OFF:    state_next.led_lit = 1'b0;
      OP_TOGGLE: state_next.led_lit = ~state.led_lit;
      default:   state_next = state;
    endcase
  end

endmodule

// ----- rtl/led_blink_pattern_sequencer_core.sv -----
// top level of the led blink pattern sequencer
//
// Status LED pattern sequencer clocked by millisecond tick items.
// Input stream s_axis carries one operation per item: tick, pattern select,
// force on, force off or toggle, with the pattern code for a select.
// Output stream m_axis returns exactly one item per input item: the LED
// level after that operation and the currently selected pattern.
// An item accepted at a clock edge shows its result on m_axis after that
// edge. Throughput is one item per cycle while the receiver does not stall,
// as the combinational state update feeds the result register.
// The block takes a new item whenever the result register is empty or its
// item is taken in the same cycle; while the receiver stalls, the result
// holds and s_axis_tready stays low.
// Reset clears the LED, selects the off pattern, stops the period counter,
// loads a 1000 ms reload period and empties the result register.
`include "led_blink_pattern_sequencer_core_macros.svh"

module led_blink_pattern_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [2:0] opcode, [5:3] pattern_code, [7:6] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] led_level, [3:1] active_pattern, [7:4] zero
);
  import lbps_pkg::*;

  lbps_state_t st;
  lbps_state_t st_next;
  logic        in_fire;
  logic        out_valid;
  logic        out_led;
  pattern_t    out_pat;

  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign in_fire = s_axis_tvalid & s_axis_tready;

  // next state for the item at the input
  lbps_step u_step (
    .state        (st),
    .opcode       (s_axis_tdata[2:0]),
    .pattern_code (s_axis_tdata[5:3]),
    .state_next   (st_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.led_lit <= 1'b0;
      st.current_pattern <= PAT_OFF;
      st.timer_running <= 1'b0;
      st.ticks_left <= '0;
      st.reload_period <= T_RESET_LOAD;
      st.blinks_done <= 2'd0;
      st.blinks_wanted <= 2'd0;
      st.pausing <= 1'b0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_led <= st_next.led_lit;
      out_pat <= st_next.current_pattern;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {4'b0000, out_pat, out_led};

  // checks
  `LBPS_ASSERT_NEXT(a_result_follows, clk, rst, in_fire, m_axis_tvalid, "no result after item")
  `LBPS_ASSERT_NEXT(a_result_matches, clk, rst, in_fire,
                    (m_axis_tdata[0] == st.led_lit) && (out_pat == st.current_pattern),
                    "result differs from state")
  `LBPS_ASSERT_ALWAYS(a_count_bounded, clk, rst,
                      !st.timer_running ||
                      ((st.ticks_left != '0) && (st.ticks_left <= st.reload_period)),
                      "period count out of range while running")
  `LBPS_ASSERT_ALWAYS(a_pause_pattern, clk, rst,
                      !st.pausing || (st.current_pattern == PAT_DOUBLE) ||
                      (st.current_pattern == PAT_TRIPLE),
                      "pause phase outside multi-blink pattern")

endmodule

// ----- test/led_blink_pattern_sequencer_core_test.sv -----
// testbench of the led blink pattern sequencer: status predictor, stimulus and checks
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_core_test;
  import lbps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 40;
  localparam int MAX_REPORTS = 200;
  localparam int PHASE_ITEMS = 360;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // predicted led status and queue of expected result items
  class led_status_model;
    logic       lit;
    pattern_t   pattern;
    logic       counting;
    period_t    remaining;
    period_t    period;
    logic [1:0] blinks_done;
    logic [1:0] blinks_wanted;
    logic       resting;
    logic [3:0] expected_status[$];
    int         errors;

    function new();
      lit = 1'b0;
      pattern = PAT_OFF;
      counting = 1'b0;
      remaining = '0;
      period = T_RESET_LOAD;
      blinks_done = '0;
      blinks_wanted = '0;
      resting = 1'b0;
      errors = 0;
    endfunction

    // restart the period counter from a new period
    function void load_period(period_t p);
      period = p;
      remaining = p;
      counting = 1'b1;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // advance the prediction by one accepted item
    function void apply_command(logic [2:0] op, logic [2:0] code);
      case (op)
        OP_TICK: begin
          if (counting) begin
            if (remaining <= period_t'(1)) begin
              remaining = period;
              // phase step on expiry
              case (pattern)
                PAT_OFF: begin
                  lit = 1'b0;
                  counting = 1'b0;
                end
                PAT_ON: begin
                  lit = 1'b1;
                  counting = 1'b0;
                end
                PAT_DOUBLE, PAT_TRIPLE: begin
                  if (resting) begin
                    resting = 1'b0;
                    blinks_done = '0;
                    lit = 1'b1;
                    load_period(T_MB_ON);
                  end else if (lit) begin
                    lit = 1'b0;
                    blinks_done = blinks_done + 2'd1;
                    if (blinks_done >= blinks_wanted) begin
                      resting = 1'b1;
                      load_period(T_MB_PAUSE);
                    end else begin
                      load_period(T_MB_OFF);
                    end
                  end else begin
                    lit = 1'b1;
                    load_period(T_MB_ON);
                  end
                end
                PAT_CONN: begin
                  if (lit) begin
                    lit = 1'b0;
                    load_period(T_CONN_OFF);
                  end else begin
                    lit = 1'b1;
                    load_period(T_CONN_ON);
                  end
                end
                default: lit = ~lit;
              endcase
            end else begin
              remaining = remaining - period_t'(1);
            end
          end
        end
        OP_SELECT: begin
          pattern = pattern_t'(code);
          blinks_done = '0;
          resting = 1'b0;
          counting = 1'b0;
          lit = 1'b1;
          case (pattern)
            PAT_OFF:     lit = 1'b0;
            PAT_ON:      lit = 1'b1;
            PAT_SLOW:    load_period(T_SLOW);
            PAT_FAST:    load_period(T_FAST);
            PAT_DOUBLE: begin
              blinks_wanted = BLINKS_DOUBLE;
              load_period(T_MB_ON);
            end
            PAT_TRIPLE: begin
              blinks_wanted = BLINKS_TRIPLE;
              load_period(T_MB_ON);
            end
            PAT_CONN:    load_period(T_CONN_ON);
            default:     load_period(T_SUNRISE);
          endcase
        end
        OP_ON:     lit = 1'b1;
        OP_OFF:    lit = 1'b0;
        OP_TOGGLE: lit = ~lit;
        default: ;
      endcase
      expected_status.push_back({pattern, lit});
    endfunction

    // compare one result item with the oldest expectation
    function void check_status(logic [7:0] data);
      logic [3:0] want;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with none expected, got 0x%02h", $time, data);
        return;
      end
      want = expected_status.pop_front();
      if (data[0] !== want[0]) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: led_level expected %0d got %0d", $time, want[0], data[0]);
      end
      if (data[3:1] !== want[3:1]) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: active_pattern expected %0d got %0d", $time, want[3:1], data[3:1]);
      end
      if (data[7:4] !== 4'd0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: tdata padding expected 0 got 0x%01h", $time, data[7:4]);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;  // [2:0] opcode, [5:3] pattern_code, [7:6] zero
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;  // [0] led_level, [3:1] active_pattern, [7:4] zero

  led_status_model status_model = new();
  int  sender_idle_pct;
  int  receiver_stall_pct;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  cycle_count = 0;
  int  counted;

  led_blink_pattern_sequencer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      status_model.check_status(m_axis_tdata);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one item and wait until it is accepted
  task automatic send_item(input logic [2:0] op, input logic [2:0] code);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {2'b00, code, op};
    do @(posedge clk); while (!s_axis_tready);
    status_model.apply_command(op, code);
    @(negedge clk);
  endtask

  // hold the input idle until every expected result has arrived
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (status_model.pending() != 0) @(negedge clk);
  endtask

  // one random phase: pattern selects followed by tick runs with forced levels and spare opcodes
  task automatic run_phase(input int quota);
    int         choice;
    int         run_len;
    logic [2:0] op;
    logic [2:0] code;
    logic       steady;
    counted = 0;
    while (counted < quota) begin
      choice = $urandom_range(99);
      if (choice < 30)      code = PAT_FAST;
      else if (choice < 50) code = PAT_DOUBLE;
      else if (choice < 70) code = PAT_TRIPLE;
      else if (choice < 78) code = PAT_SLOW;
      else if (choice < 84) code = PAT_SUNRISE;
      else if (choice < 90) code = PAT_CONN;
      else if (choice < 95) code = PAT_OFF;
      else                  code = PAT_ON;
      steady = (code == PAT_OFF) || (code == PAT_ON);
      send_item(OP_SELECT, code);
      counted++;
      run_len = steady ? $urandom_range(40, 5) : $urandom_range(450, 100);
      for (int i = 0; i < run_len && counted < quota; i++) begin
        choice = $urandom_range(99);
        code = 3'($urandom_range(7));
        if (choice < 3) begin
          op = 3'($urandom_range(OP_TOGGLE, OP_ON));
          counted++;
        end else if (choice < 4) begin
          op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_5));
        end else begin
          op = OP_TICK;
          if (!steady) counted++;
        end
        send_item(op, code);
      end
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle ticks, forced levels, spare opcodes, every pattern
    send_item(OP_TICK, 3'd5);
    send_item(OP_ON, 3'd0);
    send_item(OP_OFF, 3'd7);
    send_item(OP_TOGGLE, 3'd2);
    send_item(OP_TOGGLE, 3'd3);
    send_item(OP_SPARE_5, 3'd7);
    send_item(OP_SPARE_6, 3'd0);
    send_item(OP_SPARE_7, 3'd2);
    for (int p = 7; p >= 0; p--) begin
      send_item(OP_SELECT, p[2:0]);
      send_item(OP_TICK, 3'd7);
    end
    send_item(OP_OFF, 3'd1);
    send_item(OP_TICK, 3'd0);
    send_item(OP_TOGGLE, 3'd4);

    // no idling, starting under a long receiver hold-off
    hold_requests++;
    run_phase(PHASE_ITEMS);
    drain_results();

    sender_idle_pct = 72;
    receiver_stall_pct = 0;
    run_phase(PHASE_ITEMS);
    drain_results();

    sender_idle_pct = 0;
    receiver_stall_pct = 72;
    run_phase(PHASE_ITEMS);
    drain_results();

    sender_idle_pct = 24;
    receiver_stall_pct = 24;
    run_phase(PHASE_ITEMS);
    drain_results();

    repeat (8) @(posedge clk);
    if (status_model.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
